// ===== rtl/sbms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sbms_pkg;

    localparam int NUM_BINS_DEF = 1025;

    localparam int VAL_W      = 24;
    localparam int W_W        = 17;
    localparam int C_W        = 16;
    localparam int FG_W       = 19;
    localparam int FRAC       = 16;
    localparam int ROUND      = 32768;
    localparam int PROD_W     = VAL_W + W_W + 2;
    localparam int GAIN_W     = VAL_W + C_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [W_W-1:0]  ONE_Q16 = W_W'(65536);
    localparam logic [FG_W-1:0] FG_CAP  = FG_W'(262144);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMP_MORPH_X    = 3'd0,
        CFG_AMP_MORPH_Y    = 3'd1,
        CFG_FREQ_MORPH_X   = 3'd2,
        CFG_FREQ_MORPH_Y   = 3'd3,
        CFG_AMP_SMEAR      = 3'd4,
        CFG_FREQ_SMEAR     = 3'd5,
        CFG_GAIN_PAIR_LOW  = 3'd6,
        CFG_GAIN_PAIR_HIGH = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_store_ctl;

    typedef struct packed {
        logic [VAL_W-1:0] amp;
        logic [VAL_W-1:0] freq;
    } t_bin_val;

    function automatic logic [W_W-1:0] clamp_w(input logic [W_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    // (a*(1-w) + b*w + half) >> 16, written as a + floor(((b-a)*w + half) / 2^16)
    function automatic logic [VAL_W-1:0] lerp_q16(
        input logic [VAL_W-1:0] a,
        input logic [VAL_W-1:0] b,
        input logic [W_W-1:0]   w
    );
        logic signed [VAL_W:0]    d;
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] s;
        logic        [VAL_W:0]    r;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, w});
        s = (p + PROD_W'(ROUND)) >>> FRAC;
        r = {1'b0, a} + s[VAL_W:0];
        return r[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] apply_gain(
        input logic [VAL_W-1:0] a,
        input logic [C_W-1:0]   g
    );
        logic [GAIN_W-1:0] p;
        p = GAIN_W'(a) * GAIN_W'(g) + GAIN_W'(ROUND);
        return p[FRAC +: VAL_W];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sbms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sbms_in_if;
    logic                      valid;
    logic                      ready;
    logic [sbms_pkg::VAL_W-1:0] amp_src0;
    logic [sbms_pkg::VAL_W-1:0] amp_src1;
    logic [sbms_pkg::VAL_W-1:0] amp_src2;
    logic [sbms_pkg::VAL_W-1:0] amp_src3;
    logic [sbms_pkg::VAL_W-1:0] freq_src0;
    logic [sbms_pkg::VAL_W-1:0] freq_src1;
    logic [sbms_pkg::VAL_W-1:0] freq_src2;
    logic [sbms_pkg::VAL_W-1:0] freq_src3;
    logic [sbms_pkg::FG_W-1:0]  frame_gain;
    logic                      last_bin_in;

    modport source (
        output valid, amp_src0, amp_src1, amp_src2, amp_src3,
        output freq_src0, freq_src1, freq_src2, freq_src3, frame_gain, last_bin_in,
        input  ready
    );
    modport sink (
        input  valid, amp_src0, amp_src1, amp_src2, amp_src3,
        input  freq_src0, freq_src1, freq_src2, freq_src3, frame_gain, last_bin_in,
        output ready
    );
endinterface

interface sbms_out_if;
    logic                      valid;
    logic                      ready;
    logic [sbms_pkg::VAL_W-1:0] out_amp;
    logic [sbms_pkg::VAL_W-1:0] out_freq;
    logic                      out_last_bin;

    modport source (output valid, out_amp, out_freq, out_last_bin, input ready);
    modport sink (input valid, out_amp, out_freq, out_last_bin, output ready);
endinterface

interface sbms_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sbms_pkg::CFG_IDX_W-1:0]  idx;
    logic [sbms_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbms_bin_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbms_bin_store #(
    parameter  int NUM_BINS = sbms_pkg::NUM_BINS_DEF,
    localparam int IDX_W    = $clog2(NUM_BINS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sbms_pkg::t_store_ctl i_ctl,
    input  wire logic [IDX_W-1:0]     i_rd_idx,
    input  wire logic [IDX_W-1:0]     i_wr_idx,
    input  wire sbms_pkg::t_bin_val   i_wr_val,
    output sbms_pkg::t_bin_val        o_rd_val,
    output logic                      o_busy
);

    sbms_pkg::t_bin_val r_mem [NUM_BINS];
    sbms_pkg::t_bin_val r_rd_val;
    logic [IDX_W-1:0]   r_rd_idx;
    sbms_pkg::t_bin_val r_lw_val;
    logic [IDX_W-1:0]   r_lw_idx;
    logic               r_lw_vld;
    logic               r_busy;
    logic [IDX_W-1:0]   r_clr_addr;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    sbms_pkg::t_bin_val wr_val;

    always_comb begin
        wr_en   = r_busy || i_ctl.wr;
        wr_addr = r_busy ? r_clr_addr : i_wr_idx;
        wr_val  = r_busy ? '0 : i_wr_val;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_val;
        end
        if (i_ctl.rd) begin
            r_rd_val <= r_mem[i_rd_idx];
            r_rd_idx <= i_rd_idx;
        end
        if (i_ctl.wr) begin
            r_lw_val <= i_wr_val;
            r_lw_idx <= i_wr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_lw_vld   <= 1'b0;
        end else begin
            if (r_busy) begin
                if (r_clr_addr == IDX_W'(NUM_BINS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (i_ctl.wr) begin
                r_lw_vld <= 1'b1;
            end
        end
    end

    // take the newest write when it hit the bin just read
    assign o_rd_val = (r_lw_vld && r_lw_idx == r_rd_idx) ? r_lw_val : r_rd_val;
    assign o_busy   = r_busy;

`ifndef NO_ASSERTIONS
    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr |-> !r_busy)
        else $error("bin write during clearing pass");
    a_no_rd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rd |-> !r_busy)
        else $error("bin read during clearing pass");
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_clr_addr) == IDX_W'(NUM_BINS - 1))
        else $error("clearing pass ended early");
`endif

endmodule
`default_nettype wire

// ===== rtl/spectral_bilinear_morph_smoother.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Per-bin spectral morph of four source frames with one-pole smoothing.
// i_cfg: register writes (index, data), always ready; write only while idle.
// i_in:  one beat per bin: four amplitudes, four frequencies, frame gain and
//        the last-bin mark. Bins of a frame arrive in order from bin zero.
// o_out: one beat per input beat, in order: smoothed, scaled amplitude,
//        smoothed frequency and the last-bin mark.
// Throughput: one bin per clock while o_out is not stalled. Six register stages;
// o_out is driven from the sixth, the output register.
// Smoother memory is read as a bin enters the smoothing stage and written as
// it leaves; a one-entry bypass covers back-to-back hits on the same bin.
// Reset: registers take their reset values, then a clearing pass zeroes the
// smoother memory, one bin per cycle from bin 0 to NUM_BINS-1, with i_in.ready low.
// Stall: when o_out.ready is low the stages keep filling, empty slots close
// up, and i_in.ready drops only when all six stages hold a beat.
module spectral_bilinear_morph_smoother #(
    parameter  int NUM_BINS = sbms_pkg::NUM_BINS_DEF,
    localparam int IDX_W    = $clog2(NUM_BINS)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbms_cfg_if.sink   i_cfg,
    sbms_in_if.sink    i_in,
    sbms_out_if.source o_out
);

    localparam int VW   = sbms_pkg::VAL_W;
    localparam int OG_W = sbms_pkg::VAL_W + sbms_pkg::FG_W + 1;

    logic [sbms_pkg::W_W-1:0] r_amp_wx, r_amp_wy, r_frq_wx, r_frq_wy;
    logic [sbms_pkg::C_W-1:0] r_amp_coef, r_frq_coef;
    logic [31:0]              r_gain_lo, r_gain_hi;

    logic [IDX_W-1:0] r_bin;
    logic [IDX_W-1:0] n_bin;

    logic [6:1] r_v;
    logic [6:1] en;
    logic       acc_in;
    logic       st_busy;

    logic [VW-1:0]               r1_amp [4];
    logic [VW-1:0]               r1_fx0, r1_fx1;
    logic [sbms_pkg::FG_W-1:0]   r1_fg, r2_fg, r3_fg, r4_fg, r5_fg;
    logic                        r1_last, r2_last, r3_last, r4_last, r5_last, r6_last;
    logic [IDX_W-1:0]            r1_idx, r2_idx, r3_idx, r4_idx;
    logic [VW-1:0]               r2_ax0, r2_ax1, r2_mf;
    logic [VW-1:0]               r3_ma, r3_mf;
    logic [VW-1:0]               r4_ma, r4_mf;
    logic [VW-1:0]               r5_sa, r5_sf;
    logic [VW-1:0]               r6_amp, r6_freq;

    sbms_pkg::t_store_ctl st_ctl;
    sbms_pkg::t_bin_val   st_rd;
    sbms_pkg::t_bin_val   st_wr;

    logic [OG_W-1:0]    og_prod;
    logic [VW-1:0]      og_amp;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_wx   <= '0;
            r_amp_wy   <= '0;
            r_frq_wx   <= '0;
            r_frq_wy   <= '0;
            r_amp_coef <= '0;
            r_frq_coef <= '0;
            r_gain_lo  <= '1;
            r_gain_hi  <= '1;
        end else if (i_cfg.valid) begin
            unique case (sbms_pkg::t_cfg_idx'(i_cfg.idx))
                sbms_pkg::CFG_AMP_MORPH_X: begin
                    r_amp_wx <= sbms_pkg::clamp_w(i_cfg.data[sbms_pkg::W_W-1:0]);
                end
                sbms_pkg::CFG_AMP_MORPH_Y: begin
                    r_amp_wy <= sbms_pkg::clamp_w(i_cfg.data[sbms_pkg::W_W-1:0]);
                end
                sbms_pkg::CFG_FREQ_MORPH_X: begin
                    r_frq_wx <= sbms_pkg::clamp_w(i_cfg.data[sbms_pkg::W_W-1:0]);
                end
                sbms_pkg::CFG_FREQ_MORPH_Y: begin
                    r_frq_wy <= sbms_pkg::clamp_w(i_cfg.data[sbms_pkg::W_W-1:0]);
                end
                sbms_pkg::CFG_AMP_SMEAR: begin
                    r_amp_coef <= i_cfg.data[sbms_pkg::C_W-1:0];
                end
                sbms_pkg::CFG_FREQ_SMEAR: begin
                    r_frq_coef <= i_cfg.data[sbms_pkg::C_W-1:0];
                end
                sbms_pkg::CFG_GAIN_PAIR_LOW: begin
                    r_gain_lo <= i_cfg.data;
                end
                sbms_pkg::CFG_GAIN_PAIR_HIGH: begin
                    r_gain_hi <= i_cfg.data;
                end
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[6] = !r_v[6] || o_out.ready;
        for (int k = 5; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1] && !st_busy;
    assign acc_in     = i_in.valid && i_in.ready;

    // bin counter
    always_comb begin
        if (i_in.last_bin_in || r_bin == IDX_W'(NUM_BINS - 1)) begin
            n_bin = '0;
        end else begin
            n_bin = r_bin + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
            r_v   <= '0;
        end else begin
            if (acc_in) begin
                r_bin <= n_bin;
            end
            if (en[1]) begin
                r_v[1] <= acc_in;
            end
            for (int k = 2; k <= 6; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: source gains, frequency X mix
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_amp[0] <= sbms_pkg::apply_gain(i_in.amp_src0, r_gain_lo[15:0]);
            r1_amp[1] <= sbms_pkg::apply_gain(i_in.amp_src1, r_gain_lo[31:16]);
            r1_amp[2] <= sbms_pkg::apply_gain(i_in.amp_src2, r_gain_hi[15:0]);
            r1_amp[3] <= sbms_pkg::apply_gain(i_in.amp_src3, r_gain_hi[31:16]);
            r1_fx0    <= sbms_pkg::lerp_q16(i_in.freq_src0, i_in.freq_src1, r_frq_wx);
            r1_fx1    <= sbms_pkg::lerp_q16(i_in.freq_src2, i_in.freq_src3, r_frq_wx);
            r1_fg     <= (i_in.frame_gain > sbms_pkg::FG_CAP) ? sbms_pkg::FG_CAP
                                                              : i_in.frame_gain;
            r1_last   <= i_in.last_bin_in;
            r1_idx    <= r_bin;
        end
    end

    // stage 2: amplitude X mix, frequency Y mix
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_ax0  <= sbms_pkg::lerp_q16(r1_amp[0], r1_amp[1], r_amp_wx);
            r2_ax1  <= sbms_pkg::lerp_q16(r1_amp[2], r1_amp[3], r_amp_wx);
            r2_mf   <= sbms_pkg::lerp_q16(r1_fx0, r1_fx1, r_frq_wy);
            r2_fg   <= r1_fg;
            r2_last <= r1_last;
            r2_idx  <= r1_idx;
        end
    end

    // stage 3: amplitude Y mix
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_ma   <= sbms_pkg::lerp_q16(r2_ax0, r2_ax1, r_amp_wy);
            r3_mf   <= r2_mf;
            r3_fg   <= r2_fg;
            r3_last <= r2_last;
            r3_idx  <= r2_idx;
        end
    end

    // stage 4: smoother memory read on entry, smoothing, write-back on exit
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_ma   <= r3_ma;
            r4_mf   <= r3_mf;
            r4_fg   <= r3_fg;
            r4_last <= r3_last;
            r4_idx  <= r3_idx;
        end
    end

    always_comb begin
        st_ctl.rd  = en[4] && r_v[3];
        st_ctl.wr  = en[5] && r_v[4];
        st_wr.amp  = sbms_pkg::lerp_q16(r4_ma, st_rd.amp, {1'b0, r_amp_coef});
        st_wr.freq = sbms_pkg::lerp_q16(r4_mf, st_rd.freq, {1'b0, r_frq_coef});
    end

    sbms_bin_store #(
        .NUM_BINS (NUM_BINS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (st_ctl),
        .i_rd_idx (r3_idx),
        .i_wr_idx (r4_idx),
        .i_wr_val (st_wr),
        .o_rd_val (st_rd),
        .o_busy   (st_busy)
    );

    // stage 5: smoothed values; frame gain with saturation feeds stage 6
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_sa   <= st_wr.amp;
            r5_sf   <= st_wr.freq;
            r5_fg   <= r4_fg;
            r5_last <= r4_last;
        end
    end

    always_comb begin
        og_prod = OG_W'(r5_sa) * OG_W'(r5_fg) + OG_W'(sbms_pkg::ROUND);
        if (|og_prod[OG_W-1:VW+sbms_pkg::FRAC]) begin
            og_amp = '1;
        end else begin
            og_amp = og_prod[sbms_pkg::FRAC +: VW];
        end
    end

    // stage 6: output register
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_amp  <= og_amp;
            r6_freq <= r5_sf;
            r6_last <= r5_last;
        end
    end

    assign o_out.valid        = r_v[6];
    assign o_out.out_amp      = r6_amp;
    assign o_out.out_freq     = r6_freq;
    assign o_out.out_last_bin = r6_last;

`ifndef NO_ASSERTIONS
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin <= IDX_W'(NUM_BINS - 1))
        else $error("bin counter out of range");
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_in.last_bin_in) |=> r_bin == '0)
        else $error("bin counter did not wrap after last bin");
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |-> !st_busy)
        else $error("beat accepted during clearing pass");
`endif

endmodule
`default_nettype wire

// ===== tb/sbms_checker.sv =====
`timescale 1ns / 1ps
module sbms_checker #(
    parameter int NUM_BINS = sbms_pkg::NUM_BINS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbms_cfg_if       i_cfg,
    sbms_in_if        i_in,
    sbms_out_if       i_out,
    output int        o_fail_cnt,
    output int        o_outstanding
);

    typedef struct packed {
        logic [sbms_pkg::VAL_W-1:0] amp;
        logic [sbms_pkg::VAL_W-1:0] freq;
        logic                       last;
    } t_bin_result;

    logic [sbms_pkg::W_W-1:0]        amp_wx, amp_wy, freq_wx, freq_wy;
    logic [sbms_pkg::C_W-1:0]        amp_coef, freq_coef;
    logic [sbms_pkg::CFG_DATA_W-1:0] gains_lo, gains_hi;

    logic [sbms_pkg::VAL_W-1:0] amp_memory [NUM_BINS];
    logic [sbms_pkg::VAL_W-1:0] freq_memory [NUM_BINS];
    int                         bin_pos;
    int                         mismatches = 0;
    t_bin_result                results_due [$];

    function automatic logic [sbms_pkg::VAL_W-1:0] blend(
        input logic [sbms_pkg::VAL_W-1:0] a,
        input logic [sbms_pkg::VAL_W-1:0] b,
        input logic [sbms_pkg::W_W-1:0]   w
    );
        logic [63:0] wc;
        logic [63:0] acc;
        wc  = (w > sbms_pkg::ONE_Q16) ? 64'(sbms_pkg::ONE_Q16) : 64'(w);
        acc = 64'(a) * (64'(sbms_pkg::ONE_Q16) - wc) + 64'(b) * wc
              + 64'(sbms_pkg::ROUND);
        return acc[sbms_pkg::FRAC +: sbms_pkg::VAL_W];
    endfunction

    function automatic logic [sbms_pkg::VAL_W-1:0] mix_corners(
        input logic [sbms_pkg::VAL_W-1:0] a,
        input logic [sbms_pkg::VAL_W-1:0] b,
        input logic [sbms_pkg::VAL_W-1:0] c,
        input logic [sbms_pkg::VAL_W-1:0] d,
        input logic [sbms_pkg::W_W-1:0]   wx,
        input logic [sbms_pkg::W_W-1:0]   wy
    );
        return blend(blend(a, b, wx), blend(c, d, wx), wy);
    endfunction

    function automatic logic [sbms_pkg::VAL_W-1:0] one_pole(
        input logic [sbms_pkg::VAL_W-1:0] x,
        input logic [sbms_pkg::VAL_W-1:0] mem,
        input logic [sbms_pkg::C_W-1:0]   coef
    );
        logic [63:0] acc;
        acc = 64'(x) * (64'(sbms_pkg::ONE_Q16) - 64'(coef)) + 64'(mem) * 64'(coef)
              + 64'(sbms_pkg::ROUND);
        return acc[sbms_pkg::FRAC +: sbms_pkg::VAL_W];
    endfunction

    function automatic logic [sbms_pkg::VAL_W-1:0] source_gain(
        input logic [sbms_pkg::VAL_W-1:0] a,
        input logic [sbms_pkg::C_W-1:0]   g
    );
        logic [63:0] acc;
        acc = 64'(a) * 64'(g) + 64'(sbms_pkg::ROUND);
        return acc[sbms_pkg::FRAC +: sbms_pkg::VAL_W];
    endfunction

    function automatic void write_setting(input sbms_pkg::t_cfg_idx idx,
                                          input logic [sbms_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            sbms_pkg::CFG_AMP_MORPH_X:    amp_wx    = data[sbms_pkg::W_W-1:0];
            sbms_pkg::CFG_AMP_MORPH_Y:    amp_wy    = data[sbms_pkg::W_W-1:0];
            sbms_pkg::CFG_FREQ_MORPH_X:   freq_wx   = data[sbms_pkg::W_W-1:0];
            sbms_pkg::CFG_FREQ_MORPH_Y:   freq_wy   = data[sbms_pkg::W_W-1:0];
            sbms_pkg::CFG_AMP_SMEAR:      amp_coef  = data[sbms_pkg::C_W-1:0];
            sbms_pkg::CFG_FREQ_SMEAR:     freq_coef = data[sbms_pkg::C_W-1:0];
            sbms_pkg::CFG_GAIN_PAIR_LOW:  gains_lo  = data;
            sbms_pkg::CFG_GAIN_PAIR_HIGH: gains_hi  = data;
            default: ;
        endcase
    endfunction

    function automatic t_bin_result predict_bin();
        logic [sbms_pkg::VAL_W-1:0] a0, a1, a2, a3, f_mix, a_mix;
        logic [sbms_pkg::FG_W-1:0]  fg;
        logic [63:0]                boosted;
        t_bin_result                r;
        a0    = source_gain(i_in.amp_src0, gains_lo[15:0]);
        a1    = source_gain(i_in.amp_src1, gains_lo[31:16]);
        a2    = source_gain(i_in.amp_src2, gains_hi[15:0]);
        a3    = source_gain(i_in.amp_src3, gains_hi[31:16]);
        f_mix = mix_corners(i_in.freq_src0, i_in.freq_src1, i_in.freq_src2, i_in.freq_src3,
                            freq_wx, freq_wy);
        a_mix = mix_corners(a0, a1, a2, a3, amp_wx, amp_wy);
        freq_memory[bin_pos] = one_pole(f_mix, freq_memory[bin_pos], freq_coef);
        amp_memory[bin_pos]  = one_pole(a_mix, amp_memory[bin_pos], amp_coef);
        fg      = (i_in.frame_gain > sbms_pkg::FG_CAP) ? sbms_pkg::FG_CAP : i_in.frame_gain;
        boosted = (64'(amp_memory[bin_pos]) * 64'(fg) + 64'(sbms_pkg::ROUND))
                  >> sbms_pkg::FRAC;
        r.amp   = (boosted > 64'hFF_FFFF) ? '1 : boosted[sbms_pkg::VAL_W-1:0];
        r.freq  = freq_memory[bin_pos];
        r.last  = i_in.last_bin_in;
        bin_pos = (i_in.last_bin_in || bin_pos + 1 >= NUM_BINS) ? 0 : bin_pos + 1;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_bin_result want;
        if (!i_rst_n) begin
            amp_wx    = '0;
            amp_wy    = '0;
            freq_wx   = '0;
            freq_wy   = '0;
            amp_coef  = '0;
            freq_coef = '0;
            gains_lo  = '1;
            gains_hi  = '1;
            for (int k = 0; k < NUM_BINS; k++) begin
                amp_memory[k]  = '0;
                freq_memory[k] = '0;
            end
            bin_pos = 0;
            results_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result beat: out_amp %0h out_freq %0h out_last_bin %0b",
                           i_out.out_amp, i_out.out_freq, i_out.out_last_bin);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out.out_amp !== want.amp) begin
                        $error("out_amp: expected %0h, actual %0h", want.amp, i_out.out_amp);
                        mismatches++;
                    end
                    if (i_out.out_freq !== want.freq) begin
                        $error("out_freq: expected %0h, actual %0h", want.freq, i_out.out_freq);
                        mismatches++;
                    end
                    if (i_out.out_last_bin !== want.last) begin
                        $error("out_last_bin: expected %0b, actual %0b",
                               want.last, i_out.out_last_bin);
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready)
                write_setting(sbms_pkg::t_cfg_idx'(i_cfg.idx), i_cfg.data);
            if (i_in.valid && i_in.ready)
                results_due.insert(results_due.size(), predict_bin());
        end
        o_fail_cnt    <= mismatches;
        o_outstanding <= results_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [3:0][sbms_pkg::VAL_W-1:0] amp;
        logic [3:0][sbms_pkg::VAL_W-1:0] freq;
        logic [sbms_pkg::FG_W-1:0]       gain;
        logic                            last;
    } t_bin_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt;
    int   outstanding;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_seq      = 0;

    sbms_cfg_if cfg_ch ();
    sbms_in_if  bin_ch ();
    sbms_out_if res_ch ();

    spectral_bilinear_morph_smoother dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (bin_ch),
        .o_out  (res_ch)
    );

    sbms_checker #(
        .NUM_BINS(sbms_pkg::NUM_BINS_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (bin_ch),
        .i_out        (res_ch),
        .o_fail_cnt   (fail_cnt),
        .o_outstanding(outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [sbms_pkg::W_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return sbms_pkg::ONE_Q16;
            2:       return sbms_pkg::W_W'($urandom_range(65537, 131071));
            default: return sbms_pkg::W_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [sbms_pkg::C_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return sbms_pkg::C_W'($urandom);
        endcase
    endfunction

    function automatic logic [sbms_pkg::CFG_DATA_W-1:0] pick_gains();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return sbms_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [sbms_pkg::VAL_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return sbms_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [sbms_pkg::FG_W-1:0] pick_frame_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return sbms_pkg::FG_CAP;
            2:       return sbms_pkg::FG_W'($urandom_range(262145, 524287));
            3:       return sbms_pkg::FG_W'(65536);
            default: return sbms_pkg::FG_W'($urandom_range(0, 262144));
        endcase
    endfunction

    function automatic t_bin_beat random_beat(input logic last);
        t_bin_beat b;
        for (int i = 0; i < 4; i++) begin
            b.amp[i]  = pick_sample();
            b.freq[i] = pick_sample();
        end
        b.gain = pick_frame_gain();
        b.last = last;
        return b;
    endfunction

    function automatic t_bin_beat uniform_beat(
        input logic [sbms_pkg::VAL_W-1:0] amp,
        input logic [sbms_pkg::VAL_W-1:0] freq,
        input logic [sbms_pkg::FG_W-1:0]  gain,
        input logic                       last
    );
        t_bin_beat b;
        for (int i = 0; i < 4; i++) begin
            b.amp[i]  = amp;
            b.freq[i] = freq;
        end
        b.gain = gain;
        b.last = last;
        return b;
    endfunction

    task automatic put_setting(input sbms_pkg::t_cfg_idx idx,
                               input logic [sbms_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk iff cfg_ch.ready);
    endtask

    task automatic load_settings(
        input logic [sbms_pkg::W_W-1:0]        amx,
        input logic [sbms_pkg::W_W-1:0]        amy,
        input logic [sbms_pkg::W_W-1:0]        fmx,
        input logic [sbms_pkg::W_W-1:0]        fmy,
        input logic [sbms_pkg::C_W-1:0]        acoef,
        input logic [sbms_pkg::C_W-1:0]        fcoef,
        input logic [sbms_pkg::CFG_DATA_W-1:0] glo,
        input logic [sbms_pkg::CFG_DATA_W-1:0] ghi
    );
        put_setting(sbms_pkg::CFG_AMP_MORPH_X, sbms_pkg::CFG_DATA_W'(amx));
        put_setting(sbms_pkg::CFG_AMP_MORPH_Y, sbms_pkg::CFG_DATA_W'(amy));
        put_setting(sbms_pkg::CFG_FREQ_MORPH_X, sbms_pkg::CFG_DATA_W'(fmx));
        put_setting(sbms_pkg::CFG_FREQ_MORPH_Y, sbms_pkg::CFG_DATA_W'(fmy));
        put_setting(sbms_pkg::CFG_AMP_SMEAR, sbms_pkg::CFG_DATA_W'(acoef));
        put_setting(sbms_pkg::CFG_FREQ_SMEAR, sbms_pkg::CFG_DATA_W'(fcoef));
        put_setting(sbms_pkg::CFG_GAIN_PAIR_LOW, glo);
        put_setting(sbms_pkg::CFG_GAIN_PAIR_HIGH, ghi);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_settings();
        load_settings(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                      pick_coef(), pick_coef(), pick_gains(), pick_gains());
    endtask

    task automatic send_beat(input t_bin_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            bin_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        bin_ch.valid       <= 1'b1;
        bin_ch.amp_src0    <= b.amp[0];
        bin_ch.amp_src1    <= b.amp[1];
        bin_ch.amp_src2    <= b.amp[2];
        bin_ch.amp_src3    <= b.amp[3];
        bin_ch.freq_src0   <= b.freq[0];
        bin_ch.freq_src1   <= b.freq[1];
        bin_ch.freq_src2   <= b.freq[2];
        bin_ch.freq_src3   <= b.freq[3];
        bin_ch.frame_gain  <= b.gain;
        bin_ch.last_bin_in <= b.last;
        @(posedge i_clk iff bin_ch.ready);
    endtask

    task automatic send_frames(input int n_beats);
        int sent;
        int len;
        sent = 0;
        while (sent < n_beats) begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
            for (int i = 0; i < len; i++)
                send_beat(random_beat(i == len - 1));
            sent += len;
        end
    endtask

    task automatic wait_drained();
        bin_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    initial begin
        cfg_ch.valid       = 1'b0;
        cfg_ch.idx         = sbms_pkg::CFG_AMP_MORPH_X;
        cfg_ch.data        = '0;
        bin_ch.valid       = 1'b0;
        bin_ch.amp_src0    = '0;
        bin_ch.amp_src1    = '0;
        bin_ch.amp_src2    = '0;
        bin_ch.amp_src3    = '0;
        bin_ch.freq_src0   = '0;
        bin_ch.freq_src1   = '0;
        bin_ch.freq_src2   = '0;
        bin_ch.freq_src3   = '0;
        bin_ch.frame_gain  = '0;
        bin_ch.last_bin_in = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_settings('0, '0, '0, '0, '0, '0, '1, '1);
        send_beat(uniform_beat('0, '0, '0, 1'b1));
        send_beat(uniform_beat('1, '1, sbms_pkg::FG_CAP, 1'b1));
        send_beat(uniform_beat('1, '1, '1, 1'b1));
        send_beat(uniform_beat(24'h80_0000, 24'h00_0100, sbms_pkg::FG_W'(65536), 1'b0));
        send_beat(random_beat(1'b0));
        send_beat(random_beat(1'b1));
        wait_drained();

        load_settings(17'h1_FFFF, sbms_pkg::ONE_Q16, 17'h1_FFFF, sbms_pkg::ONE_Q16,
                      16'hFFFF, 16'hFFFF, 32'h0000_FFFF, 32'hFFFF_0000);
        send_beat(uniform_beat('1, '1, sbms_pkg::FG_CAP, 1'b0));
        for (int i = 0; i < 5; i++)
            send_beat(random_beat(i[0]));
        wait_drained();

        load_settings(17'h0_8000, 17'h1_0001, '0, 17'h1_FFFF, 16'h8000, 16'h0001,
                      '0, 32'h8000_7FFF);
        for (int i = 0; i < 6; i++)
            send_beat(random_beat(i == 5));
        wait_drained();

        send_idle_pct = 27;
        recv_idle_pct <= 82;
        random_settings();
        send_frames(30);
        wait_drained();

        send_idle_pct = 82;
        recv_idle_pct <= 27;
        random_settings();
        send_frames(15);
        wait_drained();
        random_settings();
        send_frames(15);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_settings();
        hold_seq <= hold_seq + 1;
        send_frames(10);
        for (int i = 0; i < sbms_pkg::NUM_BINS_DEF + 4; i++)
            send_beat(random_beat(1'b0));
        send_frames(10);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
